@@ rtl/core/vat_pkg.sv @@
// Package for the vertex affine transform: widths, op codes, constant tables.
// No dependencies.
`default_nettype none
package vat_pkg;
  localparam int NumVertices = 36;
  localparam int IdxW = $clog2(NumVertices);
  localparam int CordicSteps = 16;
  localparam int CubeCount = 36;

  typedef enum logic [1:0] {
    KindScale = 2'd0, KindRotate = 2'd1, KindInvRot = 2'd2, KindTranslate = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0, AxisY = 2'd1, AxisZ = 2'd2, AxisNone = 2'd3
  } axis_e;

  typedef enum logic [2:0] {
    StInit, StIdle, StCordic, StRun, StDrain
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  axis;
    logic signed [15:0] angle;
    logic signed [15:0] scale_factor;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
  } op_t;

  typedef struct packed {
    logic [5:0]         vertex_index;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] world_z;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegCenterZ = 2'd2;

  function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
    logic signed [20:0] r;
    case (i)
      4'd0: r = 21'sd51472;   4'd1: r = 21'sd30386;
      4'd2: r = 21'sd16055;   4'd3: r = 21'sd8150;
      4'd4: r = 21'sd4091;    4'd5: r = 21'sd2047;
      4'd6: r = 21'sd1024;    4'd7: r = 21'sd512;
      4'd8: r = 21'sd256;     4'd9: r = 21'sd128;
      4'd10: r = 21'sd64;     4'd11: r = 21'sd32;
      4'd12: r = 21'sd16;     4'd13: r = 21'sd8;
      4'd14: r = 21'sd4;      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  // Unit cube corners, each coordinate +-128; bit order x, y, z (1 = +).
  function automatic vec_t cube_vertex(input int unsigned i);
    logic [2:0] s;
    vec_t v;
    case (i)
      0, 5, 14, 15, 24, 29:    s = 3'b000;
      1, 20, 21, 25:           s = 3'b100;
      2, 3, 19, 31:            s = 3'b110;
      4, 13, 30, 35:           s = 3'b010;
      6, 11, 16, 28:           s = 3'b001;
      7, 22, 26, 27:           s = 3'b101;
      8, 9, 18, 23, 32, 33:    s = 3'b111;
      default:                 s = 3'b011;
    endcase
    v.x = s[2] ? 16'sd128 : -16'sd128;
    v.y = s[1] ? 16'sd128 : -16'sd128;
    v.z = s[0] ? 16'sd128 : -16'sd128;
    if (i >= CubeCount) v = '0;
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sd32767;
    else if (v < -34'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/vat_if.sv @@
// Valid/ready channel interfaces for the vertex affine transform.
// Depends on vat_pkg.
`default_nettype none
interface vat_op_if;
  logic valid;
  logic ready;
  vat_pkg::op_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vat_res_if;
  logic valid;
  logic ready;
  vat_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vat_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/core/vertex_affine_transform.sv @@
// Top level: vertex store memory, sequencer, CORDIC and datapath.
// Depends on vat_pkg, vat_if, vat_cordic, vat_datapath.
//
//  channel   dir  payload                                  role
//  op_if     in   kind, axis, angle, scale_factor, offsets one operation
//  res_if    out  vertex_index, world_x/y/z, last          one per vertex
//  cfg_if    in   index, wdata                             centre registers
//
// Rotations run the 16 CORDIC steps before the vertex pass. At most two
// vertices sit between the memory read, two datapath stages and the
// two-entry output FIFO; a stalled result port holds issue. After reset a
// fill pass loads the cube table; no operation is accepted during it.
// Config: any time.
`default_nettype none
module vertex_affine_transform (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vat_op_if.sink     op_if,
  vat_res_if.source  res_if,
  vat_cfg_if.sink    cfg_if
);
  localparam int N = vat_pkg::NumVertices;
  localparam int IW = vat_pkg::IdxW;
  localparam logic [IW:0] Last = (IW+1)'(N - 1);

  vat_pkg::state_e st_q, st_d;
  vat_pkg::op_t op_q;
  vat_pkg::vec_t center_q, mem_rd_q, loc, world;
  vat_pkg::vec_t mem [N];
  logic [IW:0] rd_cnt_q, rd_cnt_d, fill_q;
  logic [IW:0] idx1_q, idx2_q, idx3_q;
  logic v1_q, v2_q, v3_q, issue;
  logic cordic_start, cordic_done;
  logic signed [17:0] cos_w, sin_w, cos_q, sin_q;

  // output FIFO, two entries
  vat_pkg::res_t fifo_q [2];
  logic [1:0] fcnt_q;
  logic wr_ptr_q, rd_ptr_q, push, pop;
  // in flight + stored must stay within two
  logic [2:0] inflight;

  assign inflight = 3'(v1_q) + 3'(v2_q) + 3'(v3_q) + 3'(fcnt_q);
  assign cfg_if.ready = 1'b1;
  assign op_if.ready = (st_q == vat_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) center_q <= '0;
    else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        vat_pkg::RegCenterX: center_q.x <= cfg_if.wdata;
        vat_pkg::RegCenterY: center_q.y <= cfg_if.wdata;
        vat_pkg::RegCenterZ: center_q.z <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  // the CORDIC loads its angle at the accepting edge, straight from the channel
  vat_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cordic_start), .angle_i(op_if.data.angle),
    .done_o(cordic_done), .cos_o(cos_w), .sin_o(sin_w)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      vat_pkg::StInit: if (fill_q == Last) st_d = vat_pkg::StIdle;
      vat_pkg::StIdle: if (op_if.valid) begin
        st_d = (op_if.data.kind == vat_pkg::KindRotate ||
                op_if.data.kind == vat_pkg::KindInvRot) ? vat_pkg::StCordic
                                                        : vat_pkg::StRun;
      end
      vat_pkg::StCordic: if (cordic_done) st_d = vat_pkg::StRun;
      vat_pkg::StRun: if (issue && rd_cnt_q == Last) st_d = vat_pkg::StDrain;
      vat_pkg::StDrain: if (!v1_q && !v2_q && !v3_q) st_d = vat_pkg::StIdle;
      default: st_d = vat_pkg::StIdle;
    endcase
  end

  always_comb begin
    cordic_start = (st_q == vat_pkg::StIdle) && op_if.valid &&
                   (st_d == vat_pkg::StCordic);
    // issue only when the pipeline plus FIFO has room for this vertex
    issue = (st_q == vat_pkg::StRun) && (inflight < 3'd2 || (inflight == 3'd2 && pop));
    rd_cnt_d = rd_cnt_q;
    if (st_q == vat_pkg::StIdle) rd_cnt_d = '0;
    else if (issue) rd_cnt_d = rd_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= vat_pkg::StInit; fill_q <= '0; rd_cnt_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      st_q <= st_d; rd_cnt_q <= rd_cnt_d;
      if (st_q == vat_pkg::StInit) fill_q <= fill_q + 1'b1;
      v1_q <= issue; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_if.valid && op_if.ready) begin
      op_q <= op_if.data;
      cos_q <= 18'sd16384; sin_q <= '0;
    end else if (cordic_done) begin
      cos_q <= cos_w;
      sin_q <= (op_q.kind == vat_pkg::KindInvRot) ? -sin_w : sin_w;
    end
    idx1_q <= rd_cnt_q; idx2_q <= idx1_q; idx3_q <= idx2_q;
  end

  // vertex store: one read port, one write port; a vertex is written back
  // once its products are registered and never reread in the same operation
  always_ff @(posedge clk_i) begin
    if (st_q == vat_pkg::StInit)
      mem[fill_q[IW-1:0]] <= vat_pkg::cube_vertex(int'(fill_q));
    else if (v2_q)
      mem[idx2_q[IW-1:0]] <= loc;
    mem_rd_q <= mem[rd_cnt_q[IW-1:0]];
  end

  vat_datapath u_dp (
    .clk_i, .op_i(op_q), .cos_i(cos_q), .sin_i(sin_q), .v_i(mem_rd_q),
    .center_i(center_q), .local_o(loc), .world_o(world)
  );

  assign push = v3_q;
  assign pop = res_if.valid && res_if.ready;
  assign res_if.valid = (fcnt_q != 2'd0);
  assign res_if.data = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0; wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0;
    end else begin
      fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].vertex_index <= 6'(idx3_q);
      fifo_q[wr_ptr_q].world_x <= world.x;
      fifo_q[wr_ptr_q].world_y <= world.y;
      fifo_q[wr_ptr_q].world_z <= world.z;
      fifo_q[wr_ptr_q].last <= (idx3_q == Last);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/vat_cordic.sv @@
// Iterative CORDIC, one step per cycle, giving Q1.14 cos and sin.
// Depends on vat_pkg.
`default_nettype none
module vat_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] angle_i,
  output logic                    done_o,
  output logic signed [17:0]      cos_o,
  output logic signed [17:0]      sin_o
);
  localparam logic signed [20:0] HalfPi = 21'sd102944;
  localparam logic signed [20:0] Pi = 21'sd205887;

  logic signed [17:0] x_q, x_d, y_q, y_d;
  logic signed [20:0] z_q, z_d, za;
  logic [3:0] step_q, step_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; step_d = step_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    za = {{2{angle_i[15]}}, angle_i, 3'b000};
    if (start_i) begin
      neg_d = 1'b0;
      if (za > HalfPi) begin
        za = za - Pi; neg_d = 1'b1;
      end else if (za < -HalfPi) begin
        za = za + Pi; neg_d = 1'b1;
      end
      x_d = 18'sd9949; y_d = '0; z_d = za; step_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[20]) begin
        x_d = x_q - (y_q >>> step_q);
        y_d = y_q + (x_q >>> step_q);
        z_d = z_q - vat_pkg::atan_q16(step_q);
      end else begin
        x_d = x_q + (y_q >>> step_q);
        y_d = y_q - (x_q >>> step_q);
        z_d = z_q + vat_pkg::atan_q16(step_q);
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'(vat_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0; neg_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d; neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign cos_o = neg_q ? -x_q : x_q;
  assign sin_o = neg_q ? -y_q : y_q;
endmodule
`default_nettype wire

@@ rtl/core/vat_datapath.sv @@
// Per-vertex arithmetic: scale, rotate or translate, then add the centre.
// Two register stages: products, then world sums with the centre. Depends on vat_pkg.
`default_nettype none
module vat_datapath (
  input  wire logic               clk_i,
  input  wire vat_pkg::op_t       op_i,
  input  wire logic signed [17:0] cos_i,
  input  wire logic signed [17:0] sin_i,
  input  wire vat_pkg::vec_t      v_i,
  input  wire vat_pkg::vec_t      center_i,
  output vat_pkg::vec_t           local_o,
  output vat_pkg::vec_t           world_o
);
  // per output coordinate: two products, summed
  logic signed [33:0] pa_q [3], pb_q [3];
  logic signed [33:0] pa_d [3], pb_d [3];
  logic signed [17:0] vx, vy, vz, sf, ns;
  logic signed [33:0] sum [3];
  logic signed [15:0] res [3];

  always_comb begin
    vx = 18'(v_i.x); vy = 18'(v_i.y); vz = 18'(v_i.z);
    sf = 18'(op_i.scale_factor);
    ns = -sin_i;
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = '0; pb_d[k] = '0;
    end
    pa_d[0] = 34'(vx) <<< 14; pa_d[1] = 34'(vy) <<< 14; pa_d[2] = 34'(vz) <<< 14;
    unique case (op_i.kind)
      vat_pkg::KindScale: begin
        pa_d[0] = 34'(vx) * 34'(sf);
        pa_d[1] = 34'(vy) * 34'(sf);
        pa_d[2] = 34'(vz) * 34'(sf);
      end
      vat_pkg::KindTranslate: begin
        pb_d[0] = 34'(op_i.offset_x) <<< 14;
        pb_d[1] = 34'(op_i.offset_y) <<< 14;
        pb_d[2] = 34'(op_i.offset_z) <<< 14;
      end
      default: begin
        unique case (op_i.axis)
          vat_pkg::AxisX: begin
            pa_d[1] = 34'(cos_i) * 34'(vy); pb_d[1] = 34'(ns) * 34'(vz);
            pa_d[2] = 34'(sin_i) * 34'(vy); pb_d[2] = 34'(cos_i) * 34'(vz);
          end
          vat_pkg::AxisY: begin
            pa_d[0] = 34'(cos_i) * 34'(vx); pb_d[0] = 34'(sin_i) * 34'(vz);
            pa_d[2] = 34'(ns) * 34'(vx);    pb_d[2] = 34'(cos_i) * 34'(vz);
          end
          vat_pkg::AxisZ: begin
            pa_d[0] = 34'(cos_i) * 34'(vx); pb_d[0] = 34'(ns) * 34'(vy);
            pa_d[1] = 34'(sin_i) * 34'(vx); pb_d[1] = 34'(cos_i) * 34'(vy);
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= pa_d[k]; pb_q[k] <= pb_d[k];
    end
  end

  // scale products carry 8 fraction bits, all other terms 14; round half up then saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (op_i.kind == vat_pkg::KindScale) sum[k] = (pa_q[k] + pb_q[k] + 34'sd128) >>> 8;
      else sum[k] = (pa_q[k] + pb_q[k] + 34'sd8192) >>> 14;
      res[k] = vat_pkg::sat16(sum[k]);
    end
    local_o.x = res[0]; local_o.y = res[1]; local_o.z = res[2];
  end

  // world adds register this cycle's local result
  always_ff @(posedge clk_i) begin
    world_o.x <= vat_pkg::sat16(34'(local_o.x) + 34'(center_i.x));
    world_o.y <= vat_pkg::sat16(34'(local_o.y) + 34'(center_i.y));
    world_o.z <= vat_pkg::sat16(34'(local_o.z) + 34'(center_i.z));
  end
endmodule
`default_nettype wire

@@ tb/vertex_affine_transform_checker.sv @@
// Checker for the vertex affine transform: watches the operation, config and
// result channels, predicts every vertex result and compares it.
// Depends on vat_pkg and vat_if.
`timescale 1ns / 1ps
module vertex_affine_transform_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  vat_op_if.sink    op_mon,
  vat_res_if.sink   res_mon,
  vat_cfg_if.sink   cfg_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        result_count_o
);
  localparam int HalfPiQ16 = 102944;
  localparam int PiQ16 = 205887;

  vat_pkg::vec_t vertex_store [vat_pkg::NumVertices];
  logic signed [15:0] center [3];
  vat_pkg::res_t world_q[$];

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] mac_round(longint a, longint p, longint b,
                                                   longint q);
    return clamp16(floor_shr(a * p + b * q + 8192, 14));
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint c,
                               output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 8;
    x = 9949;
    y = 0;
    flip = 0;
    if (z > HalfPiQ16) begin
      z -= PiQ16;
      flip = 1;
    end else if (z < -HalfPiQ16) begin
      z += PiQ16;
      flip = 1;
    end
    for (int i = 0; i < vat_pkg::CordicSteps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(vat_pkg::atan_q16(i[3:0]));
      end else begin
        x += dx; y -= dy; z += longint'(vat_pkg::atan_q16(i[3:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic apply_operation(input vat_pkg::op_t op);
    longint c, s, x, y, z;
    vat_pkg::vec_t nv;
    vat_pkg::res_t r;
    c = 16384;
    s = 0;
    if (op.kind == vat_pkg::KindRotate || op.kind == vat_pkg::KindInvRot) begin
      cordic_sincos(op.angle, c, s);
      if (op.kind == vat_pkg::KindInvRot) s = -s;
    end
    for (int i = 0; i < vat_pkg::NumVertices; i++) begin
      x = vertex_store[i].x;
      y = vertex_store[i].y;
      z = vertex_store[i].z;
      nv = vertex_store[i];
      case (op.kind)
        vat_pkg::KindScale: begin
          nv.x = clamp16(floor_shr(x * op.scale_factor + 128, 8));
          nv.y = clamp16(floor_shr(y * op.scale_factor + 128, 8));
          nv.z = clamp16(floor_shr(z * op.scale_factor + 128, 8));
        end
        vat_pkg::KindTranslate: begin
          nv.x = clamp16(x + op.offset_x);
          nv.y = clamp16(y + op.offset_y);
          nv.z = clamp16(z + op.offset_z);
        end
        default: begin
          case (op.axis)
            vat_pkg::AxisX: begin
              nv.y = mac_round(c, y, -s, z);
              nv.z = mac_round(s, y, c, z);
            end
            vat_pkg::AxisY: begin
              nv.x = mac_round(c, x, s, z);
              nv.z = mac_round(-s, x, c, z);
            end
            vat_pkg::AxisZ: begin
              nv.x = mac_round(c, x, -s, y);
              nv.y = mac_round(s, x, c, y);
            end
            default: ;
          endcase
        end
      endcase
      vertex_store[i] = nv;
      r.vertex_index = i[5:0];
      r.world_x = clamp16(longint'(nv.x) + center[0]);
      r.world_y = clamp16(longint'(nv.y) + center[1]);
      r.world_z = clamp16(longint'(nv.z) + center[2]);
      r.last = (i == vat_pkg::NumVertices - 1);
      world_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vat_pkg::res_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < vat_pkg::NumVertices; i++) vertex_store[i] = vat_pkg::cube_vertex(i);
      center[0] = '0; center[1] = '0; center[2] = '0;
      world_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results first: an op accepted this edge cannot produce one yet
      if (res_mon.valid && res_mon.ready) begin
        a = res_mon.data;
        result_count_o <= result_count_o + 1;
        if (world_q.size() == 0) begin
          $error("result with no expectation: index %0d", a.vertex_index);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = world_q.pop_front();
          if (e != a) begin
            if (e.vertex_index != a.vertex_index)
              $error("vertex_index: expected %0d, got %0d", e.vertex_index, a.vertex_index);
            if (e.world_x != a.world_x)
              $error("world_x: expected %0d, got %0d", e.world_x, a.world_x);
            if (e.world_y != a.world_y)
              $error("world_y: expected %0d, got %0d", e.world_y, a.world_y);
            if (e.world_z != a.world_z)
              $error("world_z: expected %0d, got %0d", e.world_z, a.world_z);
            if (e.last != a.last)
              $error("last: expected %0d, got %0d", e.last, a.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          vat_pkg::RegCenterX: center[0] = cfg_mon.wdata;
          vat_pkg::RegCenterY: center[1] = cfg_mon.wdata;
          vat_pkg::RegCenterZ: center[2] = cfg_mon.wdata;
          default: ;
        endcase
      end
      if (op_mon.valid && op_mon.ready) apply_operation(op_mon.data);
      pending_o <= world_q.size();
    end
  end
endmodule

@@ tb/vertex_affine_transform_tb.sv @@
// Testbench top for vertex_affine_transform: clock, reset, operation and
// config stimulus, result back-pressure and the verdict.
// Depends on vat_pkg, vat_if, the block and vertex_affine_transform_checker.
`timescale 1ns / 1ps
module vertex_affine_transform_tb;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count, pending, result_count;
  int   op_idle_pct, res_idle_pct;
  int   idle_cycles;
  int   ops_sent;

  vat_op_if  op_if ();
  vat_res_if res_if ();
  vat_cfg_if cfg_if ();

  vertex_affine_transform DUT (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .op_if (op_if.sink), .res_if(res_if.source), .cfg_if(cfg_if.sink)
  );

  vertex_affine_transform_checker u_checker (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .op_mon (op_if.sink), .res_mon(res_if.sink), .cfg_mon(cfg_if.sink),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    op_if.valid = 0;
    op_if.data = '0;
    res_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.index = vat_pkg::RegCenterX;
    cfg_if.wdata = '0;
  end

  // result back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= res_idle_pct);
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // valid stays high into the next transaction unless the sender idles
  task automatic send_op(input vat_pkg::op_t op);
    while ($urandom_range(99) < op_idle_pct) begin
      op_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_if.valid <= 1'b1;
    op_if.data <= op;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    ops_sent++;
  endtask

  task automatic write_center(input logic [1:0] idx, input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    op_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic vat_pkg::op_t make_op(vat_pkg::kind_e k, vat_pkg::axis_e a,
                                           logic [15:0] ang, logic [15:0] sf,
                                           logic [15:0] ox, logic [15:0] oy,
                                           logic [15:0] oz);
    vat_pkg::op_t o;
    o.kind = k; o.axis = a; o.angle = ang; o.scale_factor = sf;
    o.offset_x = ox; o.offset_y = oy; o.offset_z = oz;
    return o;
  endfunction

  function automatic vat_pkg::op_t random_op();
    vat_pkg::op_t o;
    logic [95:0] rnd;
    int sel;
    rnd = {$urandom, $urandom, $urandom};
    o = rnd[$bits(vat_pkg::op_t)-1:0];
    o.angle = 16'($urandom_range(51472) - 25736);
    sel = $urandom_range(9);
    // mostly shape-preserving ops so coordinates stay away from saturation
    if (o.kind == vat_pkg::KindScale && sel < 7)
      o.scale_factor = 16'($urandom_range(384) - 64);
    if (o.kind == vat_pkg::KindTranslate && sel < 7) begin
      o.offset_x = 16'($urandom_range(1024) - 512);
      o.offset_y = 16'($urandom_range(1024) - 512);
      o.offset_z = 16'($urandom_range(1024) - 512);
    end
    return o;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_op(random_op());
      // occasional renormalize: quarter scale back toward small values
      if ($urandom_range(9) == 0)
        send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisX, 16'd0, 16'sd64,
                        16'd0, 16'd0, 16'd0));
    end
  endtask

  initial begin
    op_idle_pct = 23;
    res_idle_pct = 79;
    ops_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: each rotation axis and direction, angle extremes, no-change axis
    send_op(make_op(vat_pkg::KindRotate, vat_pkg::AxisX, 16'sd6434, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindInvRot, vat_pkg::AxisX, 16'sd6434, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindRotate, vat_pkg::AxisY, 16'sd25736, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindRotate, vat_pkg::AxisZ, -16'sd25736, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindInvRot, vat_pkg::AxisZ, 16'sd20000, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindInvRot, vat_pkg::AxisY, -16'sd20000, 16'd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindRotate, vat_pkg::AxisNone, 16'sd12868, 16'hffff, 16'hffff,
                    16'hffff, 16'hffff));
    send_op(make_op(vat_pkg::KindRotate, vat_pkg::AxisX, 16'd0, 16'd0, 16'd0, 16'd0,
                    16'd0));
    // scale and offset extremes, then restore
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisNone, 16'hffff, 16'sd32767, 16'd0,
                    16'd0, 16'd0));
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisZ, 16'd0, -16'sd32768, 16'hffff,
                    16'hffff, 16'hffff));
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisX, 16'd0, 16'sd0, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindTranslate, vat_pkg::AxisX, 16'd0, 16'd0, 16'sd32767,
                    -16'sd32768, 16'sd128));
    send_op(make_op(vat_pkg::KindTranslate, vat_pkg::AxisY, 16'hffff, 16'hffff, 16'sd32767,
                    -16'sd32768, -16'sd1));
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisX, 16'd0, 16'sd1, 16'd0, 16'd0,
                    16'd0));
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisX, 16'd0, -16'sd256, 16'd0, 16'd0,
                    16'd0));
    drain();

    write_center(vat_pkg::RegCenterX, 16'sh7fff);
    write_center(vat_pkg::RegCenterY, 16'sh8000);
    write_center(vat_pkg::RegCenterZ, 16'sd300);
    cfg_if.valid <= 1'b0;
    send_op(make_op(vat_pkg::KindTranslate, vat_pkg::AxisX, 16'd0, 16'd0, 16'sd32767,
                    -16'sd32768, -16'sd100));
    send_op(make_op(vat_pkg::KindTranslate, vat_pkg::AxisX, 16'd0, 16'd0, -16'sd32768,
                    16'sd32767, 16'sd50));
    send_op(make_op(vat_pkg::KindScale, vat_pkg::AxisX, 16'd0, 16'sd2, 16'd0, 16'd0,
                    16'd0));
    run_random(35);
    drain();

    op_idle_pct = 79;
    res_idle_pct = 23;
    write_center(vat_pkg::RegCenterX, 16'sh8000);
    write_center(vat_pkg::RegCenterY, 16'sh7fff);
    write_center(vat_pkg::RegCenterZ, 16'($urandom));
    cfg_if.valid <= 1'b0;
    run_random(35);
    drain();

    op_idle_pct = 0;
    res_idle_pct = 0;
    write_center(vat_pkg::RegCenterX, 16'($urandom));
    write_center(vat_pkg::RegCenterY, 16'($urandom));
    write_center(vat_pkg::RegCenterZ, 16'sd0);
    cfg_if.valid <= 1'b0;
    run_random(30);
    drain();

    $display("%0d operations sent, %0d vertex results checked across three config phases",
             ops_sent, result_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
